// ----- design/mmec_pkg.sv -----
// shared types, constants and code functions for the error check engine
`default_nettype none

package mmec_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CrcW    = 16;
  localparam int unsigned CodeW   = 32;
  localparam int unsigned MethodW = 3;
  localparam int unsigned HamW    = 3;

  localparam logic [CrcW-1:0] CrcStart = 16'hFFFF;
  localparam logic [CrcW-1:0] CrcPoly  = 16'hA001;

  typedef enum logic [MethodW-1:0] {
    METH_PARITY  = 3'd0,
    METH_XOR     = 3'd1,
    METH_CRC16   = 3'd2,
    METH_HAMMING = 3'd3,
    METH_SUM     = 3'd4
  } check_method_e;

  typedef struct packed {
    logic [CodeW-1:0] code;
    logic             match;
  } mmec_result_t;

  // one byte through the reflected crc-16 register, lsb first
  function automatic logic [CrcW-1:0] crc_update(input logic [CrcW-1:0] crc,
                                                 input logic [ByteW-1:0] data);
    logic [CrcW-1:0] c;
    c = crc ^ {{(CrcW-ByteW){1'b0}}, data};
    for (int k = 0; k < ByteW; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // p1,p2,p4 over the low nibble, p1 in the top bit
  function automatic logic [HamW-1:0] hamming_bits(input logic [3:0] d);
    logic p1;
    logic p2;
    logic p4;
    p1 = d[0] ^ d[1] ^ d[3];
    p2 = d[0] ^ d[2] ^ d[3];
    p4 = d[1] ^ d[2] ^ d[3];
    return {p1, p2, p4};
  endfunction

endpackage

`default_nettype wire

// ----- design/mmec_accum.sv -----
// message accumulators and code selection for the error check engine
`default_nettype none

module mmec_accum (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic [mmec_pkg::ByteW-1:0]    data_byte_i,
  input  wire logic                          last_byte_i,
  input  wire logic [mmec_pkg::CodeW-1:0]    expected_code_i,
  input  wire logic [mmec_pkg::MethodW-1:0]  check_method_i,
  output mmec_pkg::mmec_result_t             result_o
);
  import mmec_pkg::*;

  logic [CrcW-1:0]  crc_q, crc_d, crc_upd;
  logic [ByteW-1:0] xor_q, xor_d, xor_upd;
  logic             par_q, par_d, par_upd;
  logic [CodeW-1:0] sum_q, sum_d, sum_upd;
  logic [CodeW-1:0] code;
  logic             valid_method;

  assign crc_upd = crc_update(crc_q, data_byte_i);
  assign xor_upd = xor_q ^ data_byte_i;
  assign par_upd = par_q ^ (^data_byte_i);
  assign sum_upd = sum_q + {{(CodeW-ByteW){1'b0}}, data_byte_i};

  always_comb begin
    crc_d = crc_q;
    xor_d = xor_q;
    par_d = par_q;
    sum_d = sum_q;
    if (en_i) begin
      if (last_byte_i) begin
        crc_d = CrcStart;
        xor_d = '0;
        par_d = 1'b0;
        sum_d = '0;
      end else begin
        crc_d = crc_upd;
        xor_d = xor_upd;
        par_d = par_upd;
        sum_d = sum_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CrcStart;
      xor_q <= '0;
      par_q <= 1'b0;
      sum_q <= '0;
    end else begin
      crc_q <= crc_d;
      xor_q <= xor_d;
      par_q <= par_d;
      sum_q <= sum_d;
    end
  end

  // code covers the final byte as well
  always_comb begin
    code         = '0;
    valid_method = 1'b1;
    unique case (check_method_i)
      METH_PARITY:  code = {{(CodeW-1){1'b0}}, par_upd};
      METH_XOR:     code = {{(CodeW-ByteW){1'b0}}, xor_upd};
      METH_CRC16:   code = {{(CodeW-CrcW){1'b0}}, crc_upd};
      METH_HAMMING: code = {{(CodeW-HamW){1'b0}}, hamming_bits(xor_upd[3:0])};
      METH_SUM:     code = sum_upd;
      default:      valid_method = 1'b0;
    endcase
  end

  assign result_o.code  = code;
  assign result_o.match = valid_method && (code == expected_code_i);

endmodule

`default_nettype wire

// ----- design/multi_method_error_check_engine_unit.sv -----
// top level of the multi-method error check engine
`default_nettype none

// Takes a message one byte per transaction, the final byte marked by tlast,
// and keeps running bit parity, byte xor, crc-16/modbus and a 32-bit byte sum.
// On the final byte it emits one result transaction carrying the code picked
// by check_method (0 parity, 1 xor, 2 crc16, 3 hamming bits of the xor low
// nibble, 4 sum) and a match flag against the expected code sent with that
// byte; unused methods give code 0 and no match. Other bytes give no result.
// One byte per cycle is sustained while results are taken: an input register
// feeds the accumulator and compare logic into an output register, and a
// result is offered from the output register once its final byte moves on
// from the input register. A final byte waits in the input register only
// while the previous result is still unaccepted, which holds off further
// input. Write check_method only while no message is in flight.
module multi_method_error_check_engine_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_wdata_i,
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  input  wire logic [39:0] s_axis_tdata_i,  // data_byte[7:0], expected_code[39:8]
  input  wire logic        s_axis_tlast_i,  // last_byte
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output      logic [31:0] m_axis_tdata_o,  // code_value[31:0]
  output      logic [0:0]  m_axis_tuser_o   // code_matches[0]
);
  import mmec_pkg::*;

  logic [MethodW-1:0] method_q;

  logic             in_valid_q, in_valid_d;
  logic [ByteW-1:0] in_byte_q;
  logic             in_last_q;
  logic [CodeW-1:0] in_exp_q;

  logic             out_valid_q, out_valid_d;
  logic [CodeW-1:0] out_code_q;
  logic             out_match_q;

  logic         advance;
  logic         in_take;
  logic         out_load;
  mmec_result_t result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      method_q <= METH_PARITY;
    end else if (cfg_we_i) begin
      method_q <= cfg_wdata_i;
    end
  end

  // a non-final byte never needs the output slot
  assign advance  = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready_i);
  assign out_load = advance && in_last_q;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_take  = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= s_axis_tdata_i[ByteW-1:0];
      in_exp_q  <= s_axis_tdata_i[ByteW +: CodeW];
      in_last_q <= s_axis_tlast_i;
    end
    if (out_load) begin
      out_code_q  <= result.code;
      out_match_q <= result.match;
    end
  end

  mmec_accum u_accum (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (advance),
    .data_byte_i     (in_byte_q),
    .last_byte_i     (in_last_q),
    .expected_code_i (in_exp_q),
    .check_method_i  (method_q),
    .result_o        (result)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_code_q;
  assign m_axis_tuser_o  = out_match_q;

endmodule

`default_nettype wire

// ----- verif/mmec_code_checker.sv -----
// result checker for the error check engine: tracks both streams and compares codes

package mmec_check_pkg;
  import mmec_pkg::*;

  // running message state, one copy per open message
  typedef struct packed {
    logic [CrcW-1:0]  crc;
    logic [ByteW-1:0] lrc;
    logic             par;
    logic [CodeW-1:0] sum;
  } msg_accum_t;

  localparam msg_accum_t AccumStart = '{crc: CrcStart, lrc: '0, par: 1'b0, sum: '0};

  function automatic msg_accum_t accum_fold(msg_accum_t a, logic [ByteW-1:0] b);
    msg_accum_t n;
    logic fb;
    n = a;
    // crc bit at a time, lsb of the byte first
    for (int i = 0; i < ByteW; i++) begin
      fb = n.crc[0] ^ b[i];
      n.crc = n.crc >> 1;
      if (fb) begin
        n.crc = n.crc ^ CrcPoly;
      end
    end
    n.lrc = a.lrc ^ b;
    n.par = a.par ^ (^b);
    n.sum = a.sum + CodeW'(b);
    return n;
  endfunction

  function automatic logic [CodeW-1:0] method_code(msg_accum_t a, logic [MethodW-1:0] m);
    logic [CodeW-1:0] code;
    code = '0;
    case (m)
      METH_PARITY:  code[0] = a.par;
      METH_XOR:     code[ByteW-1:0] = a.lrc;
      METH_CRC16:   code[CrcW-1:0] = a.crc;
      METH_HAMMING: code[HamW-1:0] = {a.lrc[0] ^ a.lrc[1] ^ a.lrc[3],
                                      a.lrc[0] ^ a.lrc[2] ^ a.lrc[3],
                                      a.lrc[1] ^ a.lrc[2] ^ a.lrc[3]};
      METH_SUM:     code = a.sum;
      default:      code = '0;
    endcase
    return code;
  endfunction

  function automatic logic method_known(logic [MethodW-1:0] m);
    return m <= METH_SUM;
  endfunction

endpackage

module mmec_code_checker
  import mmec_pkg::*;
  import mmec_check_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [MethodW-1:0] cfg_wdata_i,
  input  logic               s_tvalid_i,
  input  logic               s_tready_i,
  input  logic [39:0]        s_tdata_i,
  input  logic               s_tlast_i,
  input  logic               m_tvalid_i,
  input  logic               m_tready_i,
  input  logic [CodeW-1:0]   m_tdata_i,
  input  logic [0:0]         m_tuser_i,
  output int unsigned        fail_count_o,
  output int unsigned        codes_pending_o,
  output int unsigned        codes_checked_o,
  output int unsigned        codes_matched_o,
  output msg_accum_t         acc_o,
  output logic [MethodW-1:0] method_o
);

  localparam int unsigned MaxReports = 10;

  msg_accum_t         acc;
  logic [MethodW-1:0] method;
  mmec_result_t       expected_results[$];

  assign acc_o    = acc;
  assign method_o = method;

  task automatic flag_mismatch(string what, logic [CodeW-1:0] want, logic [CodeW-1:0] got);
    fail_count_o++;
    if (fail_count_o <= MaxReports) begin
      $display("mismatch on %0s: expected %h, got %h (result %0d)",
               what, want, got, codes_checked_o);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    mmec_result_t want;
    if (!rst_ni) begin
      acc = AccumStart;
      method = METH_PARITY;
      expected_results.delete();
      fail_count_o = 0;
      codes_pending_o = 0;
      codes_checked_o = 0;
      codes_matched_o = 0;
    end else begin
      if (cfg_we_i) begin
        method = cfg_wdata_i;
      end
      if (s_tvalid_i && s_tready_i) begin
        acc = accum_fold(acc, s_tdata_i[ByteW-1:0]);
        if (s_tlast_i) begin
          want.code  = method_code(acc, method);
          want.match = method_known(method) && (want.code == s_tdata_i[ByteW +: CodeW]);
          expected_results.push_back(want);
          acc = AccumStart;
        end
      end
      if (m_tvalid_i && m_tready_i) begin
        if (expected_results.size() == 0) begin
          flag_mismatch("result with none outstanding", '0, m_tdata_i);
        end else begin
          want = expected_results.pop_front();
          if (m_tdata_i !== want.code) begin
            flag_mismatch("code_value", want.code, m_tdata_i);
          end
          if (m_tuser_i[0] !== want.match) begin
            flag_mismatch("code_matches", CodeW'(want.match), CodeW'(m_tuser_i[0]));
          end
          if (want.match) begin
            codes_matched_o++;
          end
        end
        codes_checked_o++;
      end
      codes_pending_o = expected_results.size();
    end
  end

endmodule

// ----- verif/multi_method_error_check_engine_unit_test.sv -----
// stimulus and verdict for the error check engine, results checked by mmec_code_checker

module multi_method_error_check_engine_unit_test;
  import mmec_pkg::*;
  import mmec_check_pkg::*;

  localparam int unsigned CycleLimit    = 400000;
  localparam int unsigned SettleCycles  = 6;
  localparam int unsigned SegmentItems  = 62;
  localparam logic [MethodW-1:0] MethodUnusedLow = 3'd5;
  localparam logic [MethodW-1:0] MethodUnusedTop = 3'd7;

  // how the expected code sent with a final byte relates to the true code
  typedef enum int unsigned {EXP_EXACT, EXP_ONE_BIT, EXP_NOISE, EXP_ZERO} exp_mode_e;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we = 1'b0;
  logic [MethodW-1:0] cfg_wdata = '0;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [39:0]        s_tdata = '0;
  logic               s_tlast = 1'b0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [CodeW-1:0]   m_tdata;
  logic [0:0]         m_tuser;

  int unsigned        fail_count;
  int unsigned        codes_pending;
  int unsigned        codes_checked;
  int unsigned        codes_matched;
  msg_accum_t         acc_now;
  logic [MethodW-1:0] method_now;

  int unsigned        send_gap_pct = 36;
  int unsigned        recv_gap_pct = 71;
  int unsigned        sent_items = 0;
  int unsigned        cycle_count = 0;
  logic [ByteW-1:0]   message_q[$];

  always #1 clk_i = ~clk_i;

  multi_method_error_check_engine_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tlast_i (s_tlast),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser)
  );

  mmec_code_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .s_tvalid_i     (s_tvalid),
    .s_tready_i     (s_tready),
    .s_tdata_i      (s_tdata),
    .s_tlast_i      (s_tlast),
    .m_tvalid_i     (m_tvalid),
    .m_tready_i     (m_tready),
    .m_tdata_i      (m_tdata),
    .m_tuser_i      (m_tuser),
    .fail_count_o   (fail_count),
    .codes_pending_o(codes_pending),
    .codes_checked_o(codes_checked),
    .codes_matched_o(codes_matched),
    .acc_o          (acc_now),
    .method_o       (method_now)
  );

  always @(negedge clk_i) begin
    m_tready <= ($urandom_range(99) >= recv_gap_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d codes still outstanding",
               cycle_count, codes_pending);
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [CodeW-1:0] pick_expected(logic [ByteW-1:0] b, exp_mode_e mode);
    logic [CodeW-1:0] code;
    code = method_code(accum_fold(acc_now, b), method_now);
    case (mode)
      EXP_EXACT:   return code;
      EXP_ONE_BIT: return code ^ (32'd1 << $urandom_range(CodeW-1));
      EXP_ZERO:    return '0;
      default:     return $urandom;
    endcase
  endfunction

  task automatic push_byte(logic [ByteW-1:0] b, logic lst, logic [CodeW-1:0] code);
    while ($urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= {32'($urandom), 8'($urandom)};
      s_tlast  <= 1'($urandom);
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {code, b};
    s_tlast  <= lst;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    sent_items++;
    @(negedge clk_i);
  endtask

  // sends message_q as one message and empties it
  task automatic send_message(exp_mode_e mode);
    for (int k = 0; k < message_q.size(); k++) begin
      if (k < message_q.size() - 1) begin
        push_byte(message_q[k], 1'b0, $urandom);
      end else begin
        push_byte(message_q[k], 1'b1, pick_expected(message_q[k], mode));
      end
    end
    message_q.delete();
  endtask

  // hold the sender until every outstanding code is out and the pipe is empty
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(negedge clk_i);
    while (codes_pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic set_method(logic [MethodW-1:0] m);
    wait_idle();
    cfg_wdata <= m;
    cfg_we    <= 1'b1;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int unsigned seg_start;
    int unsigned len;
    logic [ByteW-1:0] b;

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // method left at its reset value: parity
    message_q = '{8'h00};
    send_message(EXP_EXACT);
    message_q = '{8'hFF, 8'h01};
    send_message(EXP_EXACT);
    set_method(METH_XOR);
    message_q = '{8'hA5, 8'h5A};
    send_message(EXP_EXACT);
    message_q = '{8'h00};
    send_message(EXP_NOISE);
    // standard check string, crc 0x4b37
    set_method(METH_CRC16);
    message_q = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39};
    send_message(EXP_EXACT);
    set_method(METH_HAMMING);
    message_q = '{8'h0F};
    send_message(EXP_EXACT);
    message_q = '{8'hF0, 8'h07};
    send_message(EXP_ONE_BIT);
    set_method(METH_SUM);
    message_q = '{8'hFF, 8'hFF, 8'hFF};
    send_message(EXP_EXACT);
    // unused methods: code 0 must still report no match
    set_method(MethodUnusedTop);
    message_q = '{8'h12};
    send_message(EXP_ZERO);
    set_method(MethodUnusedLow);
    message_q = '{8'hFF};
    send_message(EXP_NOISE);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_gap_pct = 36;
          recv_gap_pct = 71;
        end
        1: begin
          send_gap_pct = 71;
          recv_gap_pct = 36;
        end
        default: begin
          send_gap_pct = 0;
          recv_gap_pct = 0;
        end
      endcase
      for (int m = 0; m < 8; m++) begin
        set_method(MethodW'(m));
        seg_start = sent_items;
        while (sent_items - seg_start < SegmentItems) begin
          len = ($urandom_range(9) == 0) ? $urandom_range(16, 48) : $urandom_range(1, 8);
          repeat (len) begin
            case ($urandom_range(9))
              0:       b = 8'h00;
              1:       b = 8'hFF;
              default: b = $urandom;
            endcase
            message_q.push_back(b);
          end
          send_message($urandom_range(1) ? EXP_EXACT : exp_mode_e'($urandom_range(3)));
          if ($urandom_range(19) == 0) begin
            wait_idle();
          end
        end
      end
    end

    wait_idle();
    $display("sent %0d bytes over all eight method settings and three stall mixes;",
             sent_items);
    $display("checked %0d codes, %0d of them matching", codes_checked, codes_matched);
    if (fail_count == 0 && codes_pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
